// ----- rtl/wpid_pkg.sv -----
//------------------------------------------------------------------------------
// wpid_pkg
// Shared types, constants and command structures of the windowed PID block.
//------------------------------------------------------------------------------
package wpid_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WLEN_W       = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int SUM_W        = 40;
    localparam int QUO_W        = 34;
    localparam logic [15:0] INTERVAL_ONE = 16'd256;
    localparam logic [WLEN_W-1:0] WLEN_RESET =
        (WINDOW_DEPTH < 16) ? WLEN_W'(WINDOW_DEPTH) : WLEN_W'(16);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 3'd0,
        REG_PGAIN  = 3'd1,
        REG_IGAIN  = 3'd2,
        REG_DGAIN  = 3'd3,
        REG_WLEN   = 3'd4
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRIME,
        ST_READ,
        ST_SUM_OLD,
        ST_SUM_NEW,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic prime_clear;
        logic prime_write;
        logic load;
        logic sum_old;
        logic sum_new;
        logic div_start;
        logic div_step;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic prime_last;
        logic div_done;
    } dp_status_t;

endpackage

// ----- rtl/wpid_stream_if.sv -----
//------------------------------------------------------------------------------
// wpid_sample_if / wpid_drive_if
// Valid/ready channels carrying input samples and output drive words.
//------------------------------------------------------------------------------
interface wpid_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_value;
    logic [15:0] sample_interval;
    modport source (output valid, output sample_value, output sample_interval, input ready);
    modport sink   (input valid, input sample_value, input sample_interval, output ready);
endinterface

interface wpid_drive_if;
    logic        valid;
    logic        ready;
    logic [31:0] drive_value;
    logic        drive_saturated;
    logic        interval_zero;
    modport source (output valid, output drive_value, output drive_saturated,
                    output interval_zero, input ready);
    modport sink   (input valid, input drive_value, input drive_saturated,
                    input interval_zero, output ready);
endinterface

// ----- rtl/windowed_pid_controller.sv -----
//------------------------------------------------------------------------------
// windowed_pid_controller
// PID controller with an integral over a sliding window of past samples.
//------------------------------------------------------------------------------
// Each word is processed in order: the ring is read and the windowed integral
// updated, the bit-serial divider forms the derivative as a 34-bit quotient,
// three passes go through the one shared 17 by 41 bit multiplier, the result
// is rounded and clipped, and it is then held in the output state until taken.
// A new word is accepted only in the idle state that follows the taken result,
// so the block takes no new word before it hands over the result of the last.
// After reset, and after every write of the target or window length, a sweep
// over every ring entry primes the ring before the next word is accepted.
module windowed_pid_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [wpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpid_pkg::CFG_DATA_W-1:0] cfg_data,
    wpid_sample_if.sink   samples,
    wpid_drive_if.source  drive
);
    import wpid_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       prime_req;

    wpid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .prime_req (prime_req),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (drive.valid),
        .out_ready (drive.ready),
        .cmd       (cmd),
        .status    (status)
    );

    wpid_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .prime_req       (prime_req),
        .sample_value    (samples.sample_value),
        .sample_interval (samples.sample_interval),
        .cmd             (cmd),
        .status          (status),
        .drive_value     (drive.drive_value),
        .drive_saturated (drive.drive_saturated),
        .interval_zero   (drive.interval_zero)
    );

endmodule

// ----- rtl/wpid_ctrl.sv -----
//------------------------------------------------------------------------------
// wpid_ctrl
// Sequencer: priming sweep, integral update, serial divide, shared multiplies.
//------------------------------------------------------------------------------
module wpid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                prime_req,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output wpid_pkg::dp_cmd_t   cmd,
    input  wpid_pkg::dp_status_t status
);
    import wpid_pkg::*;

    state_t state_reg, state_next;

    // State register; reset starts with a priming sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_PRIME;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !prime_req;
                if (prime_req)
                begin
                    cmd.prime_clear = 1'b1;
                    state_next = ST_PRIME;
                end
                else if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_PRIME:
            begin
                cmd.prime_write = 1'b1;
                if (status.prime_last)
                    state_next = ST_IDLE;
            end
            ST_READ:    state_next = ST_SUM_OLD;
            ST_SUM_OLD:
            begin
                cmd.sum_old = 1'b1;
                state_next = ST_SUM_NEW;
            end
            ST_SUM_NEW:
            begin
                cmd.sum_new   = 1'b1;
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_p = 1'b1;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_i = 1'b1;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_d = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Input is only taken in the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");
    // A loaded word always leads to the ring read.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_READ)
        else $error("load not followed by read");
    // A result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");

endmodule

// ----- rtl/wpid_datapath.sv -----
//------------------------------------------------------------------------------
// wpid_datapath
// Configuration registers, sample ring, integral, divider and multiplier.
//------------------------------------------------------------------------------
module wpid_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [wpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpid_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                  prime_req,
    input  logic [15:0]           sample_value,
    input  logic [15:0]           sample_interval,
    input  wpid_pkg::dp_cmd_t     cmd,
    output wpid_pkg::dp_status_t  status,
    output logic [31:0]           drive_value,
    output logic                  drive_saturated,
    output logic                  interval_zero
);
    import wpid_pkg::*;

    logic signed [15:0] target_reg;
    logic [15:0]        pgain_reg, igain_reg, dgain_reg;
    logic [WLEN_W-1:0]  wlen_reg;
    logic               prime_req_reg;

    logic [15:0] ring_samp [WINDOW_DEPTH];
    logic [15:0] ring_int  [WINDOW_DEPTH];
    logic [15:0] rd_samp_reg, rd_int_reg;
    logic [SLOT_W-1:0] prime_ptr_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] cur_slot;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [15:0] last_reg, samp_reg;
    logic [15:0] int_reg;

    logic [WLEN_W-1:0] wlen_w;

    assign wlen_w = cfg_data[WLEN_W-1:0];

    // Configuration writes; target and window writes request a priming sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            pgain_reg     <= '0;
            igain_reg     <= '0;
            dgain_reg     <= '0;
            wlen_reg      <= WLEN_RESET;
            prime_req_reg <= 1'b0;
        end
        else
        begin
            if (cmd.prime_clear)
                prime_req_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TARGET:
                    begin
                        target_reg    <= cfg_data;
                        prime_req_reg <= 1'b1;
                    end
                    REG_PGAIN: pgain_reg <= cfg_data;
                    REG_IGAIN: igain_reg <= cfg_data;
                    REG_DGAIN: dgain_reg <= cfg_data;
                    REG_WLEN:
                    begin
                        if (wlen_w == '0)
                            wlen_reg <= WLEN_W'(1);
                        else if (32'(wlen_w) > WINDOW_DEPTH)
                            wlen_reg <= WLEN_W'(WINDOW_DEPTH);
                        else
                            wlen_reg <= wlen_w;
                        prime_req_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end
    assign prime_req = prime_req_reg;

    // Slot in use: out-of-window slots fall back to zero.
    always_comb
    begin
        if (32'(slot_reg) >= 32'(wlen_reg))
            cur_slot = '0;
        else
            cur_slot = slot_reg;
    end

    // Ring memory: primed one entry a cycle, read at the slot, written at finish.
    always_ff @(posedge clk)
    begin
        if (cmd.prime_write)
        begin
            ring_samp[prime_ptr_reg] <= target_reg;
            ring_int[prime_ptr_reg]  <= INTERVAL_ONE;
        end
        else if (cmd.finish)
        begin
            ring_samp[cur_slot] <= samp_reg;
            ring_int[cur_slot]  <= int_reg;
        end
        rd_samp_reg <= ring_samp[cur_slot];
        rd_int_reg  <= ring_int[cur_slot];
    end

    assign status.prime_last = (32'(prime_ptr_reg) == WINDOW_DEPTH - 1);

    // Divider: |delta| * 65536 / interval, one quotient bit per cycle.
    logic [QUO_W-1:0]  div_num_reg, quo_reg;
    logic [16:0]       rem_reg;
    logic [5:0]        div_cnt_reg;
    logic              div_neg_reg;
    logic [17:0]       rem_shift;
    logic [17:0]       rem_sub;
    logic signed [16:0] delta;
    logic [16:0]        delta_abs;

    assign delta     = 17'(samp_reg) - 17'(last_reg);
    assign delta_abs = delta[16] ? 17'(-delta) : 17'(delta);
    assign rem_shift = {rem_reg, div_num_reg[QUO_W-1]};
    assign rem_sub   = rem_shift - {2'b00, int_reg};
    assign status.div_done = (div_cnt_reg == 6'd0);

    // Shared multiplier operands and accumulator (Q.8).
    logic signed [16:0] mul_a;
    logic signed [SUM_W:0] mul_b;
    logic signed [58:0] prod_reg;
    logic signed [60:0] acc_reg;
    logic signed [34:0] deriv;
    logic signed [16:0] err;
    logic signed [SUM_W-1:0] sum_next;

    assign err   = 17'(target_reg) - 17'(samp_reg);
    assign deriv = (int_reg == 16'd0) ? 35'sd0
                 : (div_neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg}));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.mul_p)
        begin
            mul_a = $signed({1'b0, pgain_reg});
            mul_b = (SUM_W+1)'(err) <<< 8;
        end
        else if (cmd.mul_i)
        begin
            mul_a = $signed({1'b0, igain_reg});
            mul_b = (SUM_W+1)'(sum_reg);
        end
        else if (cmd.mul_d)
        begin
            mul_a = $signed({1'b0, dgain_reg});
            mul_b = (SUM_W+1)'(deriv);
        end
    end

    // Integral update terms.
    logic signed [16:0] old_err;
    assign old_err = 17'(target_reg) - 17'($signed(rd_samp_reg));
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.sum_old)
            sum_next = sum_reg - SUM_W'(old_err * $signed({1'b0, rd_int_reg}));
        else if (cmd.sum_new)
            sum_next = sum_reg + SUM_W'(err * $signed({1'b0, int_reg}));
    end

    // Sequential datapath state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_ptr_reg <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            last_reg      <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.prime_write)
            begin
                prime_ptr_reg <= status.prime_last ? '0 : prime_ptr_reg + 1'b1;
                sum_reg  <= '0;
                slot_reg <= '0;
                last_reg <= target_reg;
            end
            else
            begin
                if (cmd.sum_old || cmd.sum_new)
                    sum_reg <= sum_next;
                if (cmd.div_start)
                    div_cnt_reg <= 6'(QUO_W);
                else if (cmd.div_step && div_cnt_reg != 6'd0)
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                if (cmd.finish)
                begin
                    last_reg <= samp_reg;
                    if (32'(cur_slot) + 1 >= 32'(wlen_reg))
                        slot_reg <= '0;
                    else
                        slot_reg <= cur_slot + 1'b1;
                end
            end
        end
    end

    // Payload registers.
    logic signed [60:0] acc_round;
    logic signed [52:0] drive_full;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            samp_reg <= sample_value;
            int_reg  <= sample_interval;
        end
        if (cmd.div_start)
        begin
            div_num_reg <= QUO_W'(delta_abs) << 16;
            div_neg_reg <= delta[16];
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else if (cmd.div_step && div_cnt_reg != 6'd0 && int_reg != 16'd0)
        begin
            div_num_reg <= div_num_reg << 1;
            if (!rem_sub[17])
            begin
                rem_reg <= rem_sub[16:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[16:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.mul_p || cmd.mul_i || cmd.mul_d)
            prod_reg <= 59'(mul_a * mul_b);
        if (cmd.mul_p)
            acc_reg <= '0;
        else if (cmd.mul_i || cmd.mul_d || cmd.finish)
            acc_reg <= acc_reg + 61'(prod_reg);
    end

    // Round, floor-divide by 256 and clip.
    logic sat;
    logic [31:0] clip;
    always_comb
    begin
        acc_round  = acc_reg + 61'(prod_reg) + 61'sd128;
        drive_full = 53'(acc_round >>> 8);
        sat  = 1'b0;
        clip = drive_full[31:0];
        if (drive_full > 53'sd2147483647)
        begin
            sat  = 1'b1;
            clip = 32'h7FFF_FFFF;
        end
        else if (drive_full < -53'sd2147483648)
        begin
            sat  = 1'b1;
            clip = 32'h8000_0000;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            drive_value     <= clip;
            drive_saturated <= sat;
            interval_zero   <= (int_reg == 16'd0);
        end
    end

    // The divider is never started while it is still counting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> div_cnt_reg == 6'd0)
        else $error("divider restarted while busy");
    // The ring slot always lies inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < WINDOW_DEPTH)
        else $error("ring slot out of range");
    // After finish the next slot stays inside the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> 32'(slot_reg) < 32'(wlen_reg))
        else $error("slot outside window");

endmodule

// ----- tb/sv/tb_top.sv -----
//------------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the windowed PID controller. A scoreboard
// predicts every drive word from the accepted samples and the register
// settings. Each drive word taken from the block is checked against it.
// The run covers several register settings, random idling on both channels,
// and one long output hold-off that backs up the sample channel.
//------------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wpid_pkg::*;

    // An index outside the register map; a write to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // Predicts drive words and checks the ones the block delivers.
    class pid_scoreboard;
        typedef struct {
            logic [31:0] value;
            logic        saturated;
            logic        zero;
        } drive_word_t;

        drive_word_t pending[$];
        int          errors;
        int          checked;
        int          saturations;
        int          zeros;
        longint      target, pgain, igain, dgain, wlen;
        longint      ring_sample[WINDOW_DEPTH];
        longint      ring_interval[WINDOW_DEPTH];
        longint      error_sum;
        longint      prev_sample;
        int          slot;

        function new();
            target = 0;
            pgain  = 0;
            igain  = 0;
            dgain  = 0;
            wlen   = longint'(WLEN_RESET);
            prime();
        endfunction

        // Fill the ring with the setpoint and clear the integral.
        function void prime();
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                ring_sample[i]   = target;
                ring_interval[i] = 256;
            end
            error_sum   = 0;
            slot        = 0;
            prev_sample = target;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            longint w;
            case (idx)
                REG_TARGET:
                begin
                    target = longint'($signed(data));
                    prime();
                end
                REG_PGAIN: pgain = longint'(data);
                REG_IGAIN: igain = longint'(data);
                REG_DGAIN: dgain = longint'(data);
                REG_WLEN:
                begin
                    w = longint'(data[WLEN_W-1:0]);
                    if (w == 0)
                        w = 1;
                    if (w > WINDOW_DEPTH)
                        w = WINDOW_DEPTH;
                    wlen = w;
                    prime();
                end
                default: ;
            endcase
        endfunction

        // Work out the drive word caused by one accepted sample.
        function void note_sample(logic [15:0] s_raw, logic [15:0] iv_raw);
            longint      s, iv, err, old_err, deriv, acc, drv;
            int          k;
            drive_word_t w;
            s  = longint'($signed(s_raw));
            iv = longint'(iv_raw);
            k  = slot;
            if (k >= wlen)
                k = 0;
            err     = target - s;
            old_err = target - ring_sample[k];
            error_sum = error_sum - old_err * ring_interval[k] + err * iv;
            error_sum = (error_sum <<< 24) >>> 24;
            deriv = (iv == 0) ? 0 : ((s - prev_sample) * 65536) / iv;
            acc = pgain * err * 256 + igain * error_sum + dgain * deriv + 128;
            if (acc >= 0)
                drv = acc / 256;
            else
                drv = -((-acc + 255) / 256);
            w.saturated = 1'b0;
            if (drv > 64'sd2147483647)
            begin
                drv = 64'sd2147483647;
                w.saturated = 1'b1;
            end
            else if (drv < -64'sd2147483648)
            begin
                drv = -64'sd2147483648;
                w.saturated = 1'b1;
            end
            w.value = drv[31:0];
            w.zero  = (iv == 0);
            pending.push_back(w);
            ring_sample[k]   = s;
            ring_interval[k] = iv;
            prev_sample      = s;
            k++;
            if (k >= wlen)
                k = 0;
            slot = k;
        endfunction

        function void check_drive(logic [31:0] value, logic sat, logic zero);
            drive_word_t w;
            if (pending.size() == 0)
            begin
                $display("%0t: drive word %h with nothing expected", $realtime, value);
                errors++;
                return;
            end
            w = pending.pop_front();
            checked++;
            saturations += sat;
            zeros       += zero;
            if (value !== w.value)
            begin
                $display("%0t: drive_value expected %h actual %h", $realtime, w.value, value);
                errors++;
            end
            if (sat !== w.saturated)
            begin
                $display("%0t: drive_saturated expected %b actual %b", $realtime,
                         w.saturated, sat);
                errors++;
            end
            if (zero !== w.zero)
            begin
                $display("%0t: interval_zero expected %b actual %b", $realtime, w.zero, zero);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    logic                  recv_hold;
    int                    sent;
    pid_scoreboard         sb;

    wpid_sample_if samples();
    wpid_drive_if  drive();

    windowed_pid_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples.sink),
        .drive     (drive.source)
    );

    // Clock, period 8 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Note accepted samples and check delivered drive words.
    always @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            sb.note_sample(samples.sample_value, samples.sample_interval);
        if (drive.valid && drive.ready)
            sb.check_drive(drive.drive_value, drive.drive_saturated, drive.interval_zero);
    end

    // Output side: random stalls, or a full hold-off when asked.
    always @(posedge clk)
    begin
        drive.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Write one register; the caller lowers the write enable afterwards.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Offer one word and wait until the block takes it.
    task automatic send_sample(logic [15:0] value, logic [15:0] interval);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid           <= 1'b1;
        samples.sample_value    <= value;
        samples.sample_interval <= interval;
        do
            @(posedge clk);
        while (!samples.ready);
        sent++;
    endtask

    // Mostly samples near the setpoint with ordinary intervals, some noise.
    task automatic send_random(int count);
        logic [15:0] v, iv;
        int          off;
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    v  = 16'($urandom);
                    iv = 16'($urandom);
                end
                2:
                begin
                    v  = 16'($urandom);
                    iv = 16'd0;
                end
                default:
                begin
                    off = int'($urandom_range(400)) - 200;
                    off = int'(sb.target) + off;
                    if (off > 32767)
                        off = 32767;
                    if (off < -32768)
                        off = -32768;
                    v  = off[15:0];
                    iv = 16'($urandom_range(1024, 1));
                end
            endcase
            // Idling pattern follows overall progress.
            if (sent < 240)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 54;
            end
            else if (sent < 480)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_sample(v, iv);
        end
    endtask

    // Let the block drain before touching its registers.
    task automatic drain();
        samples.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n                   <= 1'b0;
        cfg_write               <= 1'b0;
        cfg_index               <= REG_TARGET;
        cfg_data                <= '0;
        samples.valid           <= 1'b0;
        samples.sample_value    <= '0;
        samples.sample_interval <= '0;
        recv_hold               <= 1'b0;
        send_idle_pct           = 10;
        recv_idle_pct           = 54;
        sent                    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words at reset settings, then with moderate gains.
        send_sample(16'h7FFF, 16'd256);
        send_sample(16'h8000, 16'd1);
        drain();
        write_reg(REG_PGAIN, 16'd256);
        write_reg(REG_IGAIN, 16'd16);
        write_reg(REG_DGAIN, 16'd64);
        write_reg(REG_WLEN, 16'd4);
        cfg_write <= 1'b0;
        send_sample(16'h0000, 16'd256);
        send_sample(16'h7FFF, 16'd0);
        send_sample(16'h8000, 16'hFFFF);
        send_sample(16'h7FFF, 16'd1);
        send_sample(16'h8000, 16'd1);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);
        send_sample(16'h0001, 16'd0);
        send_sample(16'hFFFF, 16'd2);
        send_sample(16'h0000, 16'd0);
        drain();

        // Largest gains at a high setpoint: saturation both ways.
        write_reg(REG_TARGET, 16'h7FFF);
        write_reg(REG_PGAIN, 16'hFFFF);
        write_reg(REG_IGAIN, 16'hFFFF);
        write_reg(REG_DGAIN, 16'hFFFF);
        write_reg(REG_WLEN, 16'd16);
        cfg_write <= 1'b0;
        send_sample(16'h8000, 16'hFFFF);
        send_sample(16'h7FFF, 16'd1);
        send_sample(16'h8000, 16'd1);
        send_sample(16'h7FFF, 16'd0);
        fork
            send_random(150);
            begin
                @(posedge clk);
                recv_hold <= 1'b1;
                repeat (400) @(posedge clk);
                recv_hold <= 1'b0;
            end
        join
        drain();

        // Lowest setpoint, derivative only, shortest window; window 0 maps to 1.
        write_reg(REG_TARGET, 16'h8000);
        write_reg(REG_PGAIN, 16'd0);
        write_reg(REG_IGAIN, 16'd0);
        write_reg(REG_DGAIN, 16'hFFFF);
        write_reg(REG_WLEN, 16'd0);
        cfg_write <= 1'b0;
        send_random(130);
        drain();

        // Window above depth is clamped; unused index must change nothing.
        write_reg(REG_TARGET, 16'd100);
        write_reg(REG_PGAIN, 16'd512);
        write_reg(REG_IGAIN, 16'd1);
        write_reg(REG_DGAIN, 16'd3);
        write_reg(REG_WLEN, 16'd31);
        write_reg(REG_NONE, 16'hFFFF);
        cfg_write <= 1'b0;
        send_random(150);
        drain();

        write_reg(REG_WLEN, 16'd7);
        write_reg(REG_IGAIN, 16'd300);
        write_reg(REG_TARGET, 16'hFF00);
        cfg_write <= 1'b0;
        send_random(250);
        drain();

        $display("Checked %0d drive words (%0d saturated, %0d with zero interval)",
                 sb.checked, sb.saturations, sb.zeros);
        $display("over six register settings, idling on both sides and one long stall.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("windowed_pid_controller verification clean");
        else
            $display("windowed_pid_controller verification failed");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #5ms;
        $display("windowed_pid_controller verification failed");
        $finish;
    end

endmodule
